[hdl/hp_pkg.sv]
// ----------------------------------------------------------------------------
// hp_pkg
// Shared types and constants for the Hoare partition core.
// ----------------------------------------------------------------------------
package hp_pkg;

  localparam int KEY_W        = 64;
  localparam int SPLIT_W      = 6;
  localparam int CAPACITY_DEF = 64;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_RD,
    ST_L_CHK,
    ST_H_RD,
    ST_H_CHK,
    ST_SW_L,
    ST_SW_H,
    ST_EMIT
  } state_e;

endpackage

[hdl/hp_mem.sv]
// ----------------------------------------------------------------------------
// hp_mem
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hp_mem #(
  parameter int Depth = hp_pkg::CAPACITY_DEF,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  hp_pkg::key_t      wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output hp_pkg::key_t      rdata_o
);

  hp_pkg::key_t mem_q [Depth];
  hp_pkg::key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/hp_ctrl.sv]
// ----------------------------------------------------------------------------
// hp_ctrl
// Load, partition and emit sequencer working around the key store.
// ----------------------------------------------------------------------------
module hp_ctrl #(
  parameter int Capacity = hp_pkg::CAPACITY_DEF,
  localparam int AddrW = $clog2(Capacity),
  localparam int CntW  = $clog2(Capacity + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  hp_pkg::key_t               key_in_i,
  input  hp_pkg::key_t               pivot_in_i,
  input  logic                       last_in_i,
  // key store ports
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output hp_pkg::key_t               mem_wdata_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  hp_pkg::key_t               mem_rdata_i,
  // result side, aligned with the registered read data
  output logic [hp_pkg::SPLIT_W-1:0] split_index_o,
  output logic                       overflow_o,
  output logic                       last_out_o,
  output logic                       strobe_o
);

  localparam int SplitW = hp_pkg::SPLIT_W;

  hp_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  fill_q, fill_d;
  logic             drop_q, drop_d;
  logic             ovf_q, ovf_d;
  logic [AddrW-1:0] lo_q, lo_d;
  logic [AddrW-1:0] hi_q, hi_d;
  logic [AddrW-1:0] last_idx_q, last_idx_d;
  logic [AddrW-1:0] ei_q, ei_d;
  logic             strobe_q, strobe_d;
  logic             olast_q, olast_d;
  hp_pkg::key_t     piv_q, piv_d;
  hp_pkg::key_t     lkey_q, lkey_d;
  hp_pkg::key_t     hkey_q, hkey_d;

  logic accept;
  logic room;
  logic lo_go;
  logic hi_go;

  assign accept = start_i && !busy_o;
  assign room   = fill_q < CntW'(Capacity);
  assign lo_go  = (lo_q != last_idx_q) && ($signed(mem_rdata_i) < $signed(piv_q));
  assign hi_go  = (hi_q != '0) && ($signed(mem_rdata_i) > $signed(piv_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hp_pkg::ST_IDLE: begin
        if (accept && last_in_i) state_d = hp_pkg::ST_L_RD;
      end
      hp_pkg::ST_L_RD:  state_d = hp_pkg::ST_L_CHK;
      hp_pkg::ST_L_CHK: begin
        if (!lo_go) state_d = hp_pkg::ST_H_RD;
      end
      hp_pkg::ST_H_RD:  state_d = hp_pkg::ST_H_CHK;
      hp_pkg::ST_H_CHK: begin
        if (!hi_go) begin
          state_d = (lo_q >= hi_q) ? hp_pkg::ST_EMIT : hp_pkg::ST_SW_L;
        end
      end
      hp_pkg::ST_SW_L:  state_d = hp_pkg::ST_SW_H;
      hp_pkg::ST_SW_H:  state_d = hp_pkg::ST_L_RD;
      hp_pkg::ST_EMIT: begin
        if (ei_q == last_idx_q) state_d = hp_pkg::ST_IDLE;
      end
      default: state_d = hp_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_d      = fill_q;
    drop_d      = drop_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_idx_d  = last_idx_q;
    ei_d        = ei_q;
    strobe_d    = 1'b0;
    olast_d     = 1'b0;
    piv_d       = piv_q;
    lkey_d      = lkey_q;
    hkey_d      = hkey_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AddrW-1:0];
    mem_wdata_o = key_in_i;
    mem_raddr_o = lo_q;
    unique case (state_q)
      hp_pkg::ST_IDLE: begin
        if (accept) begin
          mem_we_o = room;
          if (room) fill_d = fill_q + CntW'(1);
          else      drop_d = 1'b1;
          if (last_in_i) begin
            // the set closes: capture its size and pivot, then reopen the store
            last_idx_d = room ? fill_q[AddrW-1:0] : AddrW'(Capacity - 1);
            piv_d      = pivot_in_i;
            ovf_d      = drop_q || !room;
            fill_d     = '0;
            drop_d     = 1'b0;
            lo_d       = '0;
            hi_d       = room ? fill_q[AddrW-1:0] : AddrW'(Capacity - 1);
          end
        end
      end
      hp_pkg::ST_L_RD: mem_raddr_o = lo_q;
      hp_pkg::ST_L_CHK: begin
        // read ahead one entry so a long run scans at one key per cycle
        mem_raddr_o = lo_q + AddrW'(1);
        if (lo_go) lo_d   = lo_q + AddrW'(1);
        else       lkey_d = mem_rdata_i;
      end
      hp_pkg::ST_H_RD: mem_raddr_o = hi_q;
      hp_pkg::ST_H_CHK: begin
        mem_raddr_o = hi_q - AddrW'(1);
        if (hi_go) hi_d   = hi_q - AddrW'(1);
        else begin
          hkey_d = mem_rdata_i;
          ei_d   = '0;
        end
      end
      hp_pkg::ST_SW_L: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q;
        mem_wdata_o = hkey_q;
      end
      hp_pkg::ST_SW_H: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hi_q;
        mem_wdata_o = lkey_q;
        lo_d        = lo_q + AddrW'(1);
        hi_d        = hi_q - AddrW'(1);
      end
      hp_pkg::ST_EMIT: begin
        mem_raddr_o = ei_q;
        strobe_d    = 1'b1;
        olast_d     = (ei_q == last_idx_q);
        ei_d        = ei_q + AddrW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hp_pkg::ST_IDLE;
      fill_q   <= '0;
      drop_q   <= 1'b0;
      ovf_q    <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
      strobe_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      ovf_q    <= ovf_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      strobe_q <= strobe_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_idx_q <= last_idx_d;
    ei_q       <= ei_d;
    piv_q      <= piv_d;
    lkey_q     <= lkey_d;
    hkey_q     <= hkey_d;
  end

  assign busy_o        = (state_q != hp_pkg::ST_IDLE);
  assign strobe_o      = strobe_q;
  assign last_out_o    = olast_q;
  assign overflow_o    = ovf_q;
  assign split_index_o = SplitW'(hi_q);

endmodule

[hdl/hoare_partition_core.sv]
// ----------------------------------------------------------------------------
// hoare_partition_core
// Loads a set of signed Q32.32 keys, Hoare-partitions it around a pivot and
// streams the keys back out in partitioned order.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start_i is high and busy_o is low. Each
// key that fits is written to the key store; keys past Capacity
// are dropped and reported on overflow_o. The transaction with last_in_i set
// also carries the pivot and closes the set; busy_o then rises.
// The partition runs against the key store (one read and one write port):
// each scan pass starts with a read state (ST_L_RD, ST_H_RD) before it
// steps through the keys, and each swap writes the low key, then the high
// key (ST_SW_L, ST_SW_H). Emission follows at one key per cycle without
// gaps; the first result shows once the sequencer is in ST_EMIT and the
// read data register holds the first key.
// Each result holds for exactly one cycle with strobe_o high; the receiver
// cannot stall. split_index_o names the last element of the low part and
// last_out_o marks the final key. busy_o drops while the final result is
// shown, so the next set may begin loading then.
// Reset clears the fill count, drop flag and sequencer; store contents
// are left as they are, and only entries written for the current set are compared or emitted.
// ----------------------------------------------------------------------------
module hoare_partition_core #(
  parameter int Capacity = hp_pkg::CAPACITY_DEF,
  localparam int AddrW = $clog2(Capacity)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  hp_pkg::key_t               key_in_i,
  input  hp_pkg::key_t               pivot_in_i,
  input  logic                       last_in_i,
  output logic                       strobe_o,
  output hp_pkg::key_t               key_out_o,
  output logic [hp_pkg::SPLIT_W-1:0] split_index_o,
  output logic                       overflow_o,
  output logic                       last_out_o
);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  hp_pkg::key_t     mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  hp_pkg::key_t     mem_rdata;

  hp_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .key_in_i      (key_in_i),
    .pivot_in_i    (pivot_in_i),
    .last_in_i     (last_in_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .split_index_o (split_index_o),
    .overflow_o    (overflow_o),
    .last_out_o    (last_out_o),
    .strobe_o      (strobe_o)
  );

  hp_mem #(
    .Depth (Capacity)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign key_out_o = mem_rdata;

  // closing a set always starts a partition
  a_last_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_in_i |=> busy_o)
    else $error("busy_o did not rise after the closing transaction");

  // results never run past the final key of a set
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_out_o |=> !strobe_o)
    else $error("result strobe after the final key");

  // only the final result may be shown while new keys are taken
  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_out_o |-> busy_o)
    else $error("non-final result while idle");

  // split index and overflow hold steady across a burst of results
  a_burst_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_out_o |=> strobe_o && $stable(split_index_o) && $stable(overflow_o))
    else $error("result burst broken or status changed mid-burst");

endmodule

[verif/hoare_partition_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hoare_partition_checker
// Watches the load and result channels of the Hoare partition core, keeps
// its own copy of the key set, partitions it when a set closes and compares
// every emitted key against the predicted order.
// ----------------------------------------------------------------------------
module hoare_partition_checker #(
  parameter int Capacity = hp_pkg::CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  hp_pkg::key_t               key_in_i,
  input  hp_pkg::key_t               pivot_in_i,
  input  logic                       last_in_i,
  input  logic                       strobe_i,
  input  hp_pkg::key_t               key_out_i,
  input  logic [hp_pkg::SPLIT_W-1:0] split_index_i,
  input  logic                       overflow_i,
  input  logic                       last_out_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  import hp_pkg::*;

  typedef struct packed {
    key_t               key;
    logic [SPLIT_W-1:0] split;
    logic               overflow;
    logic               last;
  } emitted_key_t;

  emitted_key_t emitted_q[$];
  key_t         set_keys[Capacity];
  int           fill_cnt;
  logic         keys_dropped;
  int           failures;

  // hoare scheme with both scans clamped to the loaded range
  function automatic int hoare_split(int n, key_t piv);
    int   lo;
    int   hi;
    bit   crossed;
    key_t tmp;
    lo      = -1;
    hi      = n;
    crossed = 1'b0;
    while (!crossed) begin
      lo++;
      while (lo < n - 1 && $signed(set_keys[lo]) < $signed(piv)) lo++;
      hi--;
      while (hi > 0 && $signed(set_keys[hi]) > $signed(piv)) hi--;
      if (lo >= hi) begin
        crossed = 1'b1;
      end else begin
        tmp          = set_keys[lo];
        set_keys[lo] = set_keys[hi];
        set_keys[hi] = tmp;
      end
    end
    return hi;
  endfunction

  task automatic close_set(key_t piv);
    int           n;
    int           split;
    emitted_key_t item;
    n = fill_cnt;
    if (n < 1) n = 1;
    if (n > Capacity) n = Capacity;
    split = hoare_split(n, piv);
    for (int k = 0; k < n; k++) begin
      item.key      = set_keys[k];
      item.split    = split[SPLIT_W-1:0];
      item.overflow = keys_dropped;
      item.last     = (k == n - 1);
      emitted_q.push_back(item);
    end
    fill_cnt     = 0;
    keys_dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    emitted_key_t want;
    emitted_key_t got;
    if (!rst_ni) begin
      fill_cnt     = 0;
      keys_dropped = 1'b0;
      failures     = 0;
      emitted_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results of the finishing set come out before a new key is stored
      if (strobe_i) begin
        got = {key_out_i, split_index_i, overflow_i, last_out_i};
        if (emitted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got key %h split %0d ovf %0b last %0b",
                   $time, got.key, got.split, got.overflow, got.last);
          failures++;
        end else begin
          want = emitted_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected key %h split %0d ovf %0b last %0b",
                     $time, want.key, want.split, want.overflow, want.last);
            $display("%0t:                   got key %h split %0d ovf %0b last %0b",
                     $time, got.key, got.split, got.overflow, got.last);
            failures++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (fill_cnt < Capacity) begin
          set_keys[fill_cnt] = key_in_i;
          fill_cnt++;
        end else begin
          keys_dropped = 1'b1;
        end
        if (last_in_i) close_set(pivot_in_i);
      end
      pending_o    <= emitted_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

[verif/hoare_partition_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hoare_partition_core_tb
// Feeds key sets to the Hoare partition core in random bursts: directed
// corner sets first, then random sets of mixed size, duplicates and pivots,
// including sets that overrun the store. A checker predicts and compares.
// ----------------------------------------------------------------------------
module hoare_partition_core_tb;
  import hp_pkg::*;

  localparam int   ClkHalf     = 6;
  localparam int   ResetCycles = 10;
  localparam int   RandomItems = 160;
  localparam int   IdleLimit   = 2000;
  localparam int   DrainCycles = 256;
  localparam key_t KeyMax      = {1'b0, {(KEY_W-1){1'b1}}};
  localparam key_t KeyMin      = {1'b1, {(KEY_W-1){1'b0}}};

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               start    = 1'b0;
  logic               busy;
  key_t               key_in   = '0;
  key_t               pivot_in = '0;
  logic               last_in  = 1'b0;
  logic               strobe;
  key_t               key_out;
  logic [SPLIT_W-1:0] split_index;
  logic               overflow;
  logic               last_out;

  int   pending;
  int   fail_count;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  key_t set_buf[CAPACITY_DEF+8];

  always #ClkHalf clk = ~clk;

  hoare_partition_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .key_in_i      (key_in),
    .pivot_in_i    (pivot_in),
    .last_in_i     (last_in),
    .strobe_o      (strobe),
    .key_out_o     (key_out),
    .split_index_o (split_index),
    .overflow_o    (overflow),
    .last_out_o    (last_out)
  );

  hoare_partition_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .key_in_i      (key_in),
    .pivot_in_i    (pivot_in),
    .last_in_i     (last_in),
    .strobe_i      (strobe),
    .key_out_i     (key_out),
    .split_index_i (split_index),
    .overflow_i    (overflow),
    .last_out_i    (last_out),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Q32.32 from whole and fraction parts
  function automatic key_t fix(logic [31:0] whole, logic [31:0] frac);
    return {whole, frac};
  endfunction

  function automatic key_t random_key(int mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return fix($urandom_range(0, 15) - 8, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0);
      default: begin
        case ($urandom_range(0, 3))
          0: return KeyMax;
          1: return KeyMin;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // one load transaction; drain holds the sender off until all results are out
  task automatic send_item(key_t k, key_t p, logic l, bit drain);
    key_in   <= k;
    pivot_in <= p;
    last_in  <= l;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (drain || burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      while (drain && pending != 0) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_set(int size, key_t piv, bit drain);
    for (int i = 0; i < size; i++) begin
      if (i == size - 1) send_item(set_buf[i], piv, 1'b1, drain);
      else send_item(set_buf[i], {$urandom, $urandom}, 1'b0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("hoare_partition_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int   sent;
    int   size;
    int   mode;
    bit   drain;
    key_t piv;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    burst_left = $urandom_range(0, 10);

    // single key
    set_buf[0] = KeyMax;
    send_set(1, KeyMin, 1'b0);
    // two keys on the wrong sides
    set_buf[0] = fix(5, 0);
    set_buf[1] = fix(3, 0);
    send_set(2, fix(4, 0), 1'b0);
    // pivot absent, all keys below it
    set_buf[0] = fix(-2, 0);
    set_buf[1] = KeyMin;
    set_buf[2] = fix(7, 32'h4000_0000);
    send_set(3, KeyMax, 1'b0);
    // pivot absent, all keys above it
    set_buf[0] = fix(1, 0);
    set_buf[1] = KeyMax;
    set_buf[2] = fix(-1, 32'h0000_0001);
    send_set(3, KeyMin, 1'b0);
    // extremes around a zero pivot
    set_buf[0] = KeyMax;
    set_buf[1] = KeyMin;
    set_buf[2] = '0;
    set_buf[3] = '0;
    set_buf[4] = KeyMin;
    set_buf[5] = KeyMax;
    send_set(6, '0, 1'b0);
    // every key equal to the pivot
    for (int i = 0; i < 4; i++) set_buf[i] = fix(7, 0);
    send_set(4, fix(7, 0), 1'b1);

    // random sets, the first one overruns the store by its closing key
    sent = 0;
    while (sent < RandomItems) begin
      if (sent == 0) size = CAPACITY_DEF + 1;
      else if ($urandom_range(0, 19) == 0)
        size = $urandom_range(CAPACITY_DEF - 4, CAPACITY_DEF + 3);
      else size = $urandom_range(1, 12);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < size; i++)
        set_buf[i] = random_key(mode == 3 ? $urandom_range(0, 2) : mode);
      case ($urandom_range(0, 3))
        0, 1: piv = set_buf[$urandom_range(0, size - 1)];
        2: piv = random_key(mode == 3 ? 0 : mode);
        default: piv = random_key(2);
      endcase
      drain = (sent + size >= RandomItems) || ($urandom_range(0, 7) == 0);
      send_set(size, piv, drain);
      sent += size;
    end

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("hoare_partition_core_tb passed");
    end else begin
      $display("hoare_partition_core_tb failed");
    end
    $finish;
  end

endmodule
